>>> design/urpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URI percent codec package
// Shared types, character codes and small lookup functions.
// ----------------------------------------------------------------------------
package urpc_pkg;

   localparam int QUEUE_DEPTH_DEF = 4;
   localparam int RUN_BYTES       = 3;

   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CTRL_LAST    = 8'h1F;
   localparam logic [7:0] DEL_CHAR     = 8'h7F;

   // Mode encoding: bit one selects decode, so both upper codes decode.
   localparam logic [1:0] MODE_QUERY = 2'd0;
   localparam int         MODE_DECODE_BIT = 1;

   typedef enum logic [1:0] {
      PEND_NONE = 2'd0,
      PEND_PCT  = 2'd1,
      PEND_HEX  = 2'd2
   } pend_type;

   // One queue entry: all output bytes caused by one input word.
   typedef struct packed {
      logic [RUN_BYTES-1:0][7:0] bytes;
      logic [1:0]                count;
      logic                      last;
   } run_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

   function automatic logic is_hex(input logic [7:0] c);
      return ((c >= 8'h30) && (c <= 8'h39)) ||
             ((c >= 8'h41) && (c <= 8'h46)) ||
             ((c >= 8'h61) && (c <= 8'h66));
   endfunction

   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [7:0] v;
      if (c <= 8'h39) begin
         v = 8'(c - 8'h30);
      end else if (c <= 8'h46) begin
         v = 8'(c - 8'h37);
      end else begin
         v = 8'(c - 8'h57);
      end
      return v[3:0];
   endfunction

   function automatic logic [7:0] hex_digit(input logic [3:0] n);
      logic [7:0] d;
      if (n < 4'd10) begin
         d = 8'(8'h30 + {4'h0, n});
      end else begin
         d = 8'(8'h37 + {4'h0, n});
      end
      return d;
   endfunction

   // Reserved characters that must be escaped; the query form adds / : @.
   function automatic logic in_escape_set(input logic [7:0] c, input logic query);
      logic hit;
      unique case (c)
         8'h3B, 8'h3F, 8'h26, 8'h3D, 8'h2B, 8'h24, 8'h2C, 8'h3C, 8'h3E,
         8'h23, 8'h25, 8'h22, 8'h20, 8'h7B, 8'h7D, 8'h7C, 8'h5C, 8'h5E,
         8'h5B, 8'h5D, 8'h60: hit = 1'b1;
         8'h2F, 8'h3A, 8'h40: hit = query;
         default:             hit = 1'b0;
      endcase
      return hit;
   endfunction

endpackage

>>> design/urpc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URI percent codec channels
// Valid/ready channels for input words and output words.
// ----------------------------------------------------------------------------
interface urpc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [7:0] data_byte;
   logic       string_last;

   modport source (output valid, mode, data_byte, string_last, input ready);
   modport sink   (input valid, mode, data_byte, string_last, output ready);
endinterface

interface urpc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;
   logic       string_end;

   modport source (output valid, out_byte, run_last, string_end, input ready);
   modport sink   (input valid, out_byte, run_last, string_end, output ready);
endinterface

>>> design/uri_percent_codec_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URI percent codec
// Byte-stream percent encoder and decoder with decoupled front and back end.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one input word per handshake: mode, data_byte and
//   string_last. rsp_bus returns zero to three output words per input word;
//   run_last marks the last word of each input's run and string_end the
//   final word of a string. Keep mode constant within one string.
//   Path: each output word passes the run queue, then the output register.
//   Throughput: one input word per cycle while each causes at most one
//   output and rsp_bus.ready is high; the back end sends one output word
//   per cycle while ready is high, so three-byte escapes build up and the
//   run queue (QUEUE_DEPTH runs) fills and stops req_bus until it drains.
//   When the receiver drops rsp_bus.ready the output register holds its word
//   and input keeps flowing until the queue is full.
//   Reset clears the escape state, the queue and the output valid; no
//   clearing pass is needed.
// ----------------------------------------------------------------------------
module uri_percent_codec_top #(
   parameter int QUEUE_DEPTH = urpc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   urpc_req_if.sink   req_bus,
   urpc_rsp_if.source rsp_bus
);
   import urpc_pkg::*;

   logic         push, pop;
   run_type      push_run, head_run;
   q_status_type q_status;

   urpc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .q_status (q_status),
      .push     (push),
      .push_run (push_run)
   );

   urpc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_run (push_run),
      .pop      (pop),
      .head_run (head_run),
      .q_status (q_status)
   );

   urpc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_run (head_run),
      .q_status (q_status),
      .pop      (pop),
      .rsp_bus  (rsp_bus)
   );

endmodule

>>> design/urpc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URI percent codec front end
// Accepts input words, tracks the escape state and builds the output run.
// ----------------------------------------------------------------------------
module urpc_front (
   input  logic             clock,
   input  logic             reset,
   urpc_req_if.sink         req_bus,
   input  urpc_pkg::q_status_type q_status,
   output logic             push,
   output urpc_pkg::run_type push_run
);
   import urpc_pkg::*;

   pend_type   pend_ff, pend_in;
   logic [7:0] held_ff, held_in;

   logic [RUN_BYTES-1:0][7:0] bytes;
   logic [1:0]                n;
   logic                      plain;
   logic [7:0]                c;
   logic                      accept;

   assign req_bus.ready = !q_status.full;
   assign accept        = req_bus.valid && req_bus.ready;
   assign c             = req_bus.data_byte;

   always_comb begin
      bytes   = '0;
      n       = 2'd0;
      plain   = 1'b0;
      pend_in = pend_ff;
      held_in = held_ff;
      if (req_bus.mode[MODE_DECODE_BIT]) begin
         unique case (pend_ff)
            PEND_PCT: begin
               if (is_hex(c)) begin
                  held_in = c;
                  pend_in = PEND_HEX;
               end else begin
                  bytes[n] = CHAR_PERCENT;
                  n        = 2'(n + 2'd1);
                  pend_in  = PEND_NONE;
                  plain    = 1'b1;
               end
            end
            PEND_HEX: begin
               if (is_hex(c) && is_hex(held_ff)) begin
                  bytes[n] = {hex_value(held_ff), hex_value(c)};
                  n        = 2'(n + 2'd1);
               end else begin
                  bytes[0] = CHAR_PERCENT;
                  bytes[1] = held_ff;
                  n        = 2'd2;
                  plain    = 1'b1;
               end
               pend_in = PEND_NONE;
            end
            default: begin
               pend_in = PEND_NONE;
               plain   = 1'b1;
            end
         endcase
         if (plain) begin
            if (c == CHAR_PERCENT) begin
               pend_in = PEND_PCT;
            end else begin
               bytes[n] = (c == CHAR_PLUS) ? CHAR_SPACE : c;
               n        = 2'(n + 2'd1);
            end
         end
         // Anything still held at the end of a string goes out as literals.
         if (req_bus.string_last) begin
            if ((pend_in != PEND_NONE) && (n != 2'd3)) begin
               bytes[n] = CHAR_PERCENT;
               n        = 2'(n + 2'd1);
            end
            if ((pend_in == PEND_HEX) && (n != 2'd3)) begin
               bytes[n] = held_in;
               n        = 2'(n + 2'd1);
            end
            pend_in = PEND_NONE;
         end
      end else begin
         pend_in = PEND_NONE;
         if (c == CHAR_SPACE) begin
            bytes[0] = CHAR_PLUS;
            n        = 2'd1;
         end else if ((c <= CTRL_LAST) || (c >= DEL_CHAR) ||
                      in_escape_set(c, req_bus.mode == MODE_QUERY)) begin
            bytes[0] = CHAR_PERCENT;
            bytes[1] = hex_digit(c[7:4]);
            bytes[2] = hex_digit(c[3:0]);
            n        = 2'd3;
         end else begin
            bytes[0] = c;
            n        = 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= PEND_NONE;
      end else if (accept) begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
   end

   // A word that only holds characters leaves nothing in the queue.
   assign push           = accept && (n != 2'd0);
   assign push_run.bytes = bytes;
   assign push_run.count = n;
   assign push_run.last  = req_bus.string_last;

endmodule

>>> design/urpc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URI percent codec run queue
// Short first-in first-out queue of output runs between front and back end.
// ----------------------------------------------------------------------------
module urpc_queue #(
   parameter int DEPTH = urpc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  urpc_pkg::run_type       push_run,
   input  logic                    pop,
   output urpc_pkg::run_type       head_run,
   output urpc_pkg::q_status_type  q_status
);
   import urpc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   run_type          slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign q_status.empty = (cnt_ff == '0);
   assign q_status.full  = (cnt_ff == CNT_FULL);
   assign do_push        = push && !q_status.full;
   assign do_pop         = pop && !q_status.empty;
   assign head_run       = slots_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_LAST) ? '0 : PTR_W'(wr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_LAST) ? '0 : PTR_W'(rd_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         cnt_in = CNT_W'(cnt_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         cnt_in = CNT_W'(cnt_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ff] <= push_run;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && q_status.full))
      else $error("run queue written while full");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_FULL)
      else $error("run queue count out of range");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0 || cnt_ff == CNT_FULL) |-> (wr_ff == rd_ff))
      else $error("run queue pointers disagree with count");

endmodule

>>> design/urpc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URI percent codec back end
// Walks the bytes of the head run and drives the registered output channel.
// ----------------------------------------------------------------------------
module urpc_back (
   input  logic                   clock,
   input  logic                   reset,
   input  urpc_pkg::run_type      head_run,
   input  urpc_pkg::q_status_type q_status,
   output logic                   pop,
   urpc_rsp_if.source             rsp_bus
);
   import urpc_pkg::*;

   logic [1:0] sel_ff, sel_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       run_last_ff, string_end_ff;
   logic       load, take, final_byte;

   assign load       = !valid_ff || rsp_bus.ready;
   assign take       = load && !q_status.empty;
   assign final_byte = (sel_ff == 2'(head_run.count - 2'd1));
   assign pop        = take && final_byte;

   always_comb begin
      sel_in   = sel_ff;
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
         sel_in   = final_byte ? 2'd0 : 2'(sel_ff + 2'd1);
      end else if (load) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         sel_ff   <= sel_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff       <= head_run.bytes[sel_ff];
         run_last_ff   <= final_byte;
         string_end_ff <= final_byte && head_run.last;
      end
   end

   assign rsp_bus.valid      = valid_ff;
   assign rsp_bus.out_byte   = byte_ff;
   assign rsp_bus.run_last   = run_last_ff;
   assign rsp_bus.string_end = string_end_ff;

   a_sel_in_run: assert property (@(posedge clock) disable iff (reset)
      !q_status.empty |-> (sel_ff < head_run.count))
      else $error("byte select beyond the head run");

   a_sel_idle: assert property (@(posedge clock) disable iff (reset)
      q_status.empty |-> (sel_ff == 2'd0))
      else $error("byte select left mid-run with empty queue");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && string_end_ff) |-> run_last_ff)
      else $error("string end on a word that does not close its run");

endmodule
